// ----- rtl/core/presence_dwell_event_fsm_core_macros.svh -----
// Assertion macros for the presence/dwell event core checker.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef PRESENCE_DWELL_EVENT_FSM_CORE_MACROS_SVH
`define PRESENCE_DWELL_EVENT_FSM_CORE_MACROS_SVH

// same-cycle implication
`define PDEF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PDEF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pdef_pkg.sv -----
// Shared types and constants for the presence/dwell event core.
// No dependencies.
`default_nettype none

package pdef_pkg;

    localparam int TIME_BITS = 32;
    localparam int CFG_W     = 24;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int SCORE_W   = 8;
    localparam int EV_W      = 3;
    localparam int RSN_W     = 2;
    localparam int IDX_W     = ADDR_W - 2;

    localparam logic [CFG_W-1:0] RST_DWELL_START = CFG_W'(3000);
    localparam logic [CFG_W-1:0] RST_ZONE_TIME   = CFG_W'(2000);
    localparam logic [CFG_W-1:0] RST_LOST        = CFG_W'(1500);
    localparam logic [CFG_W-1:0] RST_GRACE       = CFG_W'(0);
    localparam logic [CFG_W-1:0] RST_AFTER_LEAVE = CFG_W'(10000);

    typedef enum logic [EV_W-1:0] {
        EV_NONE        = 3'd0,
        EV_PRES_START  = 3'd1,
        EV_DWELL_START = 3'd2,
        EV_DWELL_END   = 3'd3,
        EV_PRES_END    = 3'd4,
        EV_INTERACTION = 3'd5
    } t_event;

    typedef enum logic [RSN_W-1:0] {
        RSN_NONE  = 2'd0,
        RSN_DWELL = 2'd1,
        RSN_ZONE  = 2'd2
    } t_reason;

    typedef enum logic [IDX_W-1:0] {
        REG_DWELL_START = 3'd0,
        REG_ZONE_TIME   = 3'd1,
        REG_LOST        = 3'd2,
        REG_GRACE       = 3'd3,
        REG_AFTER_LEAVE = 3'd4
    } t_reg_idx;

endpackage

`default_nettype wire

// ----- rtl/core/presence_dwell_event_fsm_core.sv -----
// Presence/dwell event core: top level with input register, event logic,
// result register and APB register file. Depends on pdef_pkg.
//
// One vision sample per transfer; one result per sample. The core takes a new
// sample every cycle unless a stalled result holds the input register. While a
// sample sits in the input register, a single pass of compares and 32-bit
// modular subtractions updates the tracking state and loads the result register
// as the sample moves on. The result register holds while the consumer stalls;
// the input register accepts as soon as its sample moves on.
`default_nettype none

module presence_dwell_event_fsm_core
    import pdef_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_person_seen,
    input  wire logic [SCORE_W-1:0]   i_detect_score,
    input  wire logic [TIME_BITS-1:0] i_now_time,
    input  wire logic [TIME_BITS-1:0] i_zone_stable_since,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [EV_W-1:0]           o_event_code,
    output logic [RSN_W-1:0]          o_reason_code,
    output logic                      o_is_present,
    output logic                      o_is_dwelling,
    output logic [TIME_BITS-1:0]      o_presence_elapsed,
    output logic [TIME_BITS-1:0]      o_dwell_elapsed,
    output logic [SCORE_W-1:0]        o_confidence,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    logic [CFG_W-1:0] r_dwell_start_time, r_zone_time, r_lost, r_grace, r_after_leave;
    logic [IDX_W-1:0] w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_start_time <= RST_DWELL_START;
            r_zone_time        <= RST_ZONE_TIME;
            r_lost             <= RST_LOST;
            r_grace            <= RST_GRACE;
            r_after_leave      <= RST_AFTER_LEAVE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DWELL_START: r_dwell_start_time <= pwdata[CFG_W-1:0];
                REG_ZONE_TIME:   r_zone_time        <= pwdata[CFG_W-1:0];
                REG_LOST:        r_lost             <= pwdata[CFG_W-1:0];
                REG_GRACE:       r_grace            <= pwdata[CFG_W-1:0];
                REG_AFTER_LEAVE: r_after_leave      <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DWELL_START: prdata = DATA_W'(r_dwell_start_time);
            REG_ZONE_TIME:   prdata = DATA_W'(r_zone_time);
            REG_LOST:        prdata = DATA_W'(r_lost);
            REG_GRACE:       prdata = DATA_W'(r_grace);
            REG_AFTER_LEAVE: prdata = DATA_W'(r_after_leave);
            default:         prdata = '0;
        endcase
    end

    // input register
    logic                 r_in_valid, r_in_seen;
    logic [SCORE_W-1:0]   r_in_score;
    logic [TIME_BITS-1:0] r_in_now, r_in_zone;
    logic                 w_adv;

    assign w_adv   = r_in_valid && (!o_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_seen  <= i_person_seen;
            r_in_score <= i_detect_score;
            r_in_now   <= i_now_time;
            r_in_zone  <= i_zone_stable_since;
        end
    end

    // tracking state
    logic                 r_present, r_dwell, r_cand, r_dl, r_il, r_idone;
    logic [TIME_BITS-1:0] r_pstart, r_last_seen, r_dstart, r_last_leave, r_leave_ack;
    logic                 n_present, n_dwell, n_cand, n_dl, n_il, n_idone;
    logic [TIME_BITS-1:0] n_pstart, n_last_seen, n_dstart, n_last_leave, n_leave_ack;
    t_event               w_ev;
    t_reason              w_rsn;
    logic [TIME_BITS-1:0] w_d_pstart, w_d_zone, w_d_seen, w_d_leave;
    logic                 w_idone_eff, w_lost, w_left;

    assign w_d_pstart = r_in_now - r_pstart;
    assign w_d_zone   = r_in_now - r_in_zone;
    assign w_d_seen   = r_in_now - r_last_seen;
    assign w_d_leave  = r_in_now - r_last_leave;
    assign w_lost     = r_present && (w_d_seen > TIME_BITS'(r_lost));
    assign w_left     = !r_present && (r_last_leave != '0);

    always_comb begin
        n_present   = r_present;
        n_dwell     = r_dwell;
        n_cand      = r_cand;
        n_dl        = r_dl;
        n_il        = r_il;
        n_idone     = r_idone;
        n_pstart    = r_pstart;
        n_last_seen = r_last_seen;
        n_dstart    = r_dstart;
        n_last_leave = r_last_leave;
        n_leave_ack = r_leave_ack;
        w_ev        = EV_NONE;
        w_rsn       = RSN_NONE;
        w_idone_eff = r_idone;
        if (r_in_seen) begin
            n_last_seen = r_in_now;
            if (!r_present) begin
                n_present = 1'b1;
                n_dwell   = 1'b0;
                n_pstart  = r_in_now;
                n_cand    = 1'b0;
                n_dl      = 1'b0;
                n_il      = 1'b0;
                n_idone   = 1'b0;
                w_ev      = EV_PRES_START;
            end else if (!r_dwell && w_d_pstart >= TIME_BITS'(r_dwell_start_time)) begin
                n_dwell  = 1'b1;
                n_dstart = r_in_now;
                w_ev     = EV_DWELL_START;
            end else begin
                n_cand = r_cand || (w_d_zone >= TIME_BITS'(r_zone_time));
                if (r_dwell) n_dl = 1'b1;
                if (n_cand)  n_il = 1'b1;
            end
        end else if (w_lost) begin
            if (r_dwell && (r_grace == '0 || w_d_seen >= TIME_BITS'(r_grace))) begin
                n_dwell = 1'b0;
                w_ev    = EV_DWELL_END;
            end else begin
                n_dwell      = 1'b0;
                n_present    = 1'b0;
                n_last_leave = r_in_now;
                w_ev         = EV_PRES_END;
            end
        end else if (w_left) begin
            if (r_last_leave != r_leave_ack) begin
                n_leave_ack = r_last_leave;
                w_idone_eff = 1'b0;
                n_idone     = 1'b0;
            end
            if (!w_idone_eff) begin
                if ((r_dl || r_il) && w_d_leave <= TIME_BITS'(r_after_leave)) begin
                    n_idone = 1'b1;
                    w_rsn   = r_dl ? RSN_DWELL : RSN_ZONE;
                    n_dl    = 1'b0;
                    n_il    = 1'b0;
                    w_ev    = EV_INTERACTION;
                end else if (w_d_leave > TIME_BITS'(r_after_leave)) begin
                    n_idone = 1'b1;
                    n_dl    = 1'b0;
                    n_il    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present    <= 1'b0;
            r_dwell      <= 1'b0;
            r_cand       <= 1'b0;
            r_dl         <= 1'b0;
            r_il         <= 1'b0;
            r_idone      <= 1'b0;
            r_pstart     <= '0;
            r_last_seen  <= '0;
            r_dstart     <= '0;
            r_last_leave <= '0;
            r_leave_ack  <= '0;
        end else if (w_adv) begin
            r_present    <= n_present;
            r_dwell      <= n_dwell;
            r_cand       <= n_cand;
            r_dl         <= n_dl;
            r_il         <= n_il;
            r_idone      <= n_idone;
            r_pstart     <= n_pstart;
            r_last_seen  <= n_last_seen;
            r_dstart     <= n_dstart;
            r_last_leave <= n_last_leave;
            r_leave_ack  <= n_leave_ack;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_event_code       <= w_ev;
            o_reason_code      <= w_rsn;
            o_is_present       <= n_present;
            o_is_dwelling      <= n_dwell;
            o_presence_elapsed <= n_present ? (r_in_now - n_pstart) : '0;
            o_dwell_elapsed    <= n_dwell ? (r_in_now - n_dstart) : '0;
            o_confidence       <= r_in_seen ? r_in_score : '0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pdef_checker.sv -----
// Port-level checker for the presence/dwell event core, bound to the top level.
// Depends on pdef_pkg and presence_dwell_event_fsm_core_macros.svh.
`default_nettype none

`include "presence_dwell_event_fsm_core_macros.svh"

module pdef_checker
    import pdef_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_valid,
    input wire logic                 i_ready,
    input wire logic [EV_W-1:0]      o_event_code,
    input wire logic [RSN_W-1:0]     o_reason_code,
    input wire logic                 o_is_present,
    input wire logic                 o_is_dwelling,
    input wire logic [TIME_BITS-1:0] o_presence_elapsed
);

    `PDEF_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_event_code) && $stable(o_presence_elapsed), "stalled result changed")
    `PDEF_ASSERT_NOW(a_reason_only_interaction, o_valid && o_reason_code != RSN_NONE, o_event_code == EV_INTERACTION, "reason on non-interaction event")
    `PDEF_ASSERT_NOW(a_dwell_needs_presence, o_valid && o_is_dwelling, o_is_present, "dwelling while absent")
    `PDEF_ASSERT_NOW(a_absent_zero_elapsed, o_valid && !o_is_present, o_presence_elapsed == '0, "elapsed nonzero while absent")

endmodule

bind presence_dwell_event_fsm_core pdef_checker u_pdef_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_event_code       (o_event_code),
    .o_reason_code      (o_reason_code),
    .o_is_present       (o_is_present),
    .o_is_dwelling      (o_is_dwelling),
    .o_presence_elapsed (o_presence_elapsed)
);

`default_nettype wire
